[hdl/tql_pkg.sv]
// Shared types and constants of the tabular Q-learning agent.
// No dependencies; every other file of the block but tql_ram imports this package.
package tql_pkg;

    localparam int SCORE_W = 7;
    localparam int ACT_W   = 4;
    localparam int Q_W     = 32;
    localparam int MUL_A_W = 35;
    localparam int MUL_B_W = 17;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int RND_W   = PROD_W - 16;

    localparam logic signed [RND_W-1:0] REWARD_Q = RND_W'(500 * 65536);
    localparam logic signed [Q_W-1:0]   Q_MAX    = 32'sh7FFF_FFFF;
    localparam logic signed [Q_W-1:0]   Q_MIN    = 32'sh8000_0000;

    localparam logic [2:0] REG_GOAL      = 3'd0;
    localparam logic [2:0] REG_EPS_START = 3'd1;
    localparam logic [2:0] REG_EPS_STEP  = 3'd2;
    localparam logic [2:0] REG_EPS_FLOOR = 3'd3;
    localparam logic [2:0] REG_LRATE     = 3'd4;
    localparam logic [2:0] REG_DISCOUNT  = 3'd5;

    localparam logic [6:0]  RST_GOAL      = 7'd100;
    localparam logic [31:0] RST_EPS_START = 32'hFFFF_FFFF;
    localparam logic [15:0] RST_EPS_STEP  = 16'd13;
    localparam logic [31:0] RST_EPS_FLOOR = 32'd21474836;
    localparam logic [15:0] RST_LRATE     = 16'd1966;
    localparam logic [15:0] RST_DISCOUNT  = 16'd62259;

    typedef enum logic [1:0] {
        FUNC_ACT   = 2'd0,
        FUNC_LEARN = 2'd1,
        FUNC_WRITE = 2'd2,
        FUNC_NOP   = 2'd3
    } t_func;

    typedef struct packed {
        t_func                     func;
        logic [SCORE_W-1:0]        own_score;
        logic [SCORE_W-1:0]        opp_score;
        logic [31:0]               rand_explore;
        logic [ACT_W-1:0]          rand_action;
        logic [ACT_W-1:0]          write_action;
        logic signed [Q_W-1:0]     write_value;
    } t_cmd;

    typedef struct packed {
        logic signed [4:0]         action;
        logic signed [Q_W-1:0]     q_value;
    } t_result;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ROW,
        ST_BASE,
        ST_SCAN,
        ST_SCAN_END,
        ST_PROW,
        ST_PBASE,
        ST_RDCUR,
        ST_MUL1,
        ST_TGT,
        ST_MUL2,
        ST_UPD,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic sel_prev;
        logic row_en;
        logic base_en;
    } t_addr_ctl;

endpackage

[hdl/tabular_q_learning_agent.sv]
// Top level of the tabular Q-learning agent: sequencer, config registers, datapath.
// Depends on tql_pkg, tql_ram, tql_addr and tql_mul.
//
//  channel   | handshake                          | payload
//  ----------+------------------------------------+-----------------------
//  command   | start / busy (taken: start & !busy)| i_cmd    (t_cmd)
//  result    | o_done, one cycle, no backpressure | o_result (t_result)
//  config    | psel/penable/pwrite/pready         | paddr, pwdata, prdata
//
// After the accepting edge busy stays high until the command is through; o_done shows
// in the cycle busy drops. Write, no-op and exploring act skip the table scan; a greedy
// act scans the table with one RAM read per action, and learn adds the two dependent
// products through the one shared multiplier.
// Synchronous active-low reset sets control, agent state and config to their reset values;
// the per-command registers and the table are not cleared. Results cannot be stalled.
module tabular_q_learning_agent import tql_pkg::*; #(
    parameter int NUM_ACTIONS  = 12,
    parameter int SCORE_LEVELS = 101
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_cmd        i_cmd,
    output logic        o_done,
    output t_result     o_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int DEPTH = SCORE_LEVELS * SCORE_LEVELS * NUM_ACTIONS;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [SCORE_W-1:0] SCORE_MAX = SCORE_W'(SCORE_LEVELS - 1);
    localparam logic [ACT_W-1:0]   ACT_LAST  = ACT_W'(NUM_ACTIONS - 1);
    localparam logic [ACT_W:0]     ACT_NUM   = (ACT_W + 1)'(NUM_ACTIONS);

    function automatic logic [SCORE_W-1:0] clamp_score(input logic [SCORE_W-1:0] v);
        return (v > SCORE_MAX) ? SCORE_MAX : v;
    endfunction

    function automatic logic [ACT_W-1:0] act_mod(input logic [ACT_W-1:0] v);
        logic [ACT_W:0] t;
        t = {1'b0, v};
        for (int k = 0; k < 8; k++) begin
            if (t >= ACT_NUM) begin
                t = t - ACT_NUM;
            end
        end
        return t[ACT_W-1:0];
    endfunction

    function automatic logic signed [RND_W-1:0] rnd_q16(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] s;
        s = p + PROD_W'(32768);
        return RND_W'(s >>> 16);
    endfunction

    // config registers
    logic [6:0]  r_goal;
    logic [31:0] r_eps_start;
    logic [15:0] r_eps_step;
    logic [31:0] r_eps_floor;
    logic [15:0] r_lrate;
    logic [15:0] r_discount;
    logic        cfg_we;

    // sequencer and item state
    t_state                r_state, n_state;
    t_func                 r_func, n_func;
    logic [SCORE_W-1:0]    r_p, n_p;
    logic [SCORE_W-1:0]    r_o, n_o;
    logic                  r_explore, n_explore;
    logic [ACT_W-1:0]      r_ract, n_ract;
    logic [ACT_W-1:0]      r_wact, n_wact;
    logic signed [Q_W-1:0] r_wval, n_wval;
    logic [SCORE_W-1:0]    r_prev_p, n_prev_p;
    logic [SCORE_W-1:0]    r_prev_o, n_prev_o;
    logic [ACT_W-1:0]      r_last, n_last;
    logic [31:0]           r_eps, n_eps;
    logic [ACT_W-1:0]      r_idx, n_idx;
    logic [ACT_W-1:0]      r_cmp_idx, n_cmp_idx;
    logic signed [Q_W-1:0] r_best, n_best;
    logic [ACT_W-1:0]      r_best_idx, n_best_idx;
    logic signed [Q_W-1:0] r_cur, n_cur;
    logic signed [MUL_A_W-1:0] r_diff, n_diff;
    logic                  r_done, n_done;
    t_result               r_res, n_res;

    // datapath
    t_addr_ctl                 addr_ctl;
    logic [ACT_W-1:0]          idx_sel;
    logic [AW-1:0]             ram_addr;
    logic                      ram_we;
    logic [Q_W-1:0]            ram_wdata;
    logic [Q_W-1:0]            ram_rdata;
    logic signed [Q_W-1:0]     rd_val;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic signed [RND_W-1:0]   rnd_v;
    logic signed [RND_W-1:0]   reward;
    logic signed [RND_W-1:0]   tgt;
    logic signed [RND_W:0]     diff_w;
    logic signed [RND_W:0]     sum_w;
    logic signed [Q_W-1:0]     nv_sat;
    logic [32:0]               eps_dec;
    logic [31:0]               eps_next;
    logic [ACT_W-1:0]          act_pick;
    logic                      cmp_vld;

    tql_addr #(
        .NUM_ACTIONS  (NUM_ACTIONS),
        .SCORE_LEVELS (SCORE_LEVELS)
    ) u_addr (
        .i_clk    (i_clk),
        .i_ctl    (addr_ctl),
        .i_cur_p  (r_p),
        .i_cur_o  (r_o),
        .i_prev_p (r_prev_p),
        .i_prev_o (r_prev_o),
        .i_idx    (idx_sel),
        .o_addr   (ram_addr)
    );

    tql_ram #(
        .WIDTH (Q_W),
        .DEPTH (DEPTH)
    ) u_qtab (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_addr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_addr),
        .o_rdata (ram_rdata)
    );

    tql_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    // config port
    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal      <= RST_GOAL;
            r_eps_start <= RST_EPS_START;
            r_eps_step  <= RST_EPS_STEP;
            r_eps_floor <= RST_EPS_FLOOR;
            r_lrate     <= RST_LRATE;
            r_discount  <= RST_DISCOUNT;
        end else if (cfg_we) begin
            unique case (paddr[4:2])
                REG_GOAL:      r_goal      <= pwdata[6:0];
                REG_EPS_START: r_eps_start <= pwdata;
                REG_EPS_STEP:  r_eps_step  <= pwdata[15:0];
                REG_EPS_FLOOR: r_eps_floor <= pwdata;
                REG_LRATE:     r_lrate     <= pwdata[15:0];
                REG_DISCOUNT:  r_discount  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_GOAL:      prdata = {25'd0, r_goal};
            REG_EPS_START: prdata = r_eps_start;
            REG_EPS_STEP:  prdata = {16'd0, r_eps_step};
            REG_EPS_FLOOR: prdata = r_eps_floor;
            REG_LRATE:     prdata = {16'd0, r_lrate};
            REG_DISCOUNT:  prdata = {16'd0, r_discount};
            default:       prdata = '0;
        endcase
    end

    // arithmetic
    assign rd_val = $signed(ram_rdata);
    assign rnd_v  = rnd_q16(mul_p);

    always_comb begin
        if (r_o >= r_goal) begin
            reward = -REWARD_Q;
        end else if (r_p >= r_goal) begin
            reward = REWARD_Q;
        end else begin
            reward = '0;
        end
    end

    assign tgt    = reward + rnd_v;
    assign diff_w = (RND_W + 1)'(tgt) - (RND_W + 1)'(r_cur);
    assign sum_w  = (RND_W + 1)'(r_cur) + (RND_W + 1)'(rnd_v);

    always_comb begin
        if (sum_w > (RND_W + 1)'(Q_MAX)) begin
            nv_sat = Q_MAX;
        end else if (sum_w < (RND_W + 1)'(Q_MIN)) begin
            nv_sat = Q_MIN;
        end else begin
            nv_sat = Q_W'(sum_w);
        end
    end

    assign eps_dec  = {1'b0, r_eps} - {17'd0, r_eps_step};
    assign eps_next = ($signed(eps_dec) < $signed({1'b0, r_eps_floor})) ? r_eps_floor
                                                                       : eps_dec[31:0];
    assign act_pick = r_explore ? act_mod(r_ract) : r_best_idx;
    assign cmp_vld  = ((r_state == ST_SCAN) && (r_idx != '0)) || (r_state == ST_SCAN_END);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_prev_p <= '0;
            r_prev_o <= '0;
            r_last   <= '0;
            r_eps    <= RST_EPS_START;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_prev_p <= n_prev_p;
            r_prev_o <= n_prev_o;
            r_last   <= n_last;
            r_eps    <= n_eps;
            r_done   <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func     <= n_func;
        r_p        <= n_p;
        r_o        <= n_o;
        r_explore  <= n_explore;
        r_ract     <= n_ract;
        r_wact     <= n_wact;
        r_wval     <= n_wval;
        r_idx      <= n_idx;
        r_cmp_idx  <= n_cmp_idx;
        r_best     <= n_best;
        r_best_idx <= n_best_idx;
        r_cur      <= n_cur;
        r_diff     <= n_diff;
        r_res      <= n_res;
    end

    always_comb begin
        n_state    = r_state;
        n_func     = r_func;
        n_p        = r_p;
        n_o        = r_o;
        n_explore  = r_explore;
        n_ract     = r_ract;
        n_wact     = r_wact;
        n_wval     = r_wval;
        n_prev_p   = r_prev_p;
        n_prev_o   = r_prev_o;
        n_last     = r_last;
        n_eps      = r_eps;
        n_idx      = r_idx;
        n_cmp_idx  = r_cmp_idx;
        n_best     = r_best;
        n_best_idx = r_best_idx;
        n_cur      = r_cur;
        n_diff     = r_diff;
        n_done     = 1'b0;
        n_res      = r_res;
        addr_ctl   = '0;
        idx_sel    = r_last;
        ram_we     = 1'b0;
        ram_wdata  = nv_sat;
        mul_a      = r_diff;
        mul_b      = $signed({1'b0, r_lrate});

        if (cfg_we && (paddr[4:2] == REG_EPS_START)) begin
            n_eps = pwdata;
        end

        if (cmp_vld && ((r_cmp_idx == '0) || (rd_val > r_best))) begin
            n_best     = rd_val;
            n_best_idx = r_cmp_idx;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state   = ST_ROW;
                    n_func    = i_cmd.func;
                    n_p       = clamp_score(i_cmd.own_score);
                    n_o       = clamp_score(i_cmd.opp_score);
                    n_explore = i_cmd.rand_explore < r_eps;
                    n_ract    = i_cmd.rand_action;
                    n_wact    = i_cmd.write_action;
                    n_wval    = i_cmd.write_value;
                end
            end
            ST_ROW: begin
                addr_ctl.row_en = 1'b1;
                n_state         = ST_BASE;
            end
            ST_BASE: begin
                addr_ctl.base_en = 1'b1;
                n_idx            = '0;
                unique case (r_func)
                    FUNC_ACT:   n_state = r_explore ? ST_FIN : ST_SCAN;
                    FUNC_LEARN: n_state = ST_SCAN;
                    default:    n_state = ST_FIN;
                endcase
            end
            ST_SCAN: begin
                idx_sel   = r_idx;
                n_idx     = r_idx + 1'b1;
                n_cmp_idx = r_idx;
                if (r_idx == ACT_LAST) begin
                    n_state = ST_SCAN_END;
                end
            end
            ST_SCAN_END: begin
                n_state = (r_func == FUNC_LEARN) ? ST_PROW : ST_FIN;
            end
            ST_PROW: begin
                addr_ctl.sel_prev = 1'b1;
                addr_ctl.row_en   = 1'b1;
                n_state           = ST_PBASE;
            end
            ST_PBASE: begin
                addr_ctl.sel_prev = 1'b1;
                addr_ctl.base_en  = 1'b1;
                n_state           = ST_RDCUR;
            end
            ST_RDCUR: begin
                n_state = ST_MUL1;
            end
            ST_MUL1: begin
                n_cur   = rd_val;
                mul_a   = MUL_A_W'(r_best);
                mul_b   = $signed({1'b0, r_discount});
                n_state = ST_TGT;
            end
            ST_TGT: begin
                n_diff  = MUL_A_W'(diff_w);
                n_state = ST_MUL2;
            end
            ST_MUL2: begin
                n_state = ST_UPD;
            end
            ST_UPD: begin
                ram_we          = 1'b1;
                n_res           = '0;
                n_res.q_value   = nv_sat;
                n_done          = 1'b1;
                n_prev_p        = r_p;
                n_prev_o        = r_o;
                n_state         = ST_IDLE;
            end
            ST_FIN: begin
                n_res   = '0;
                n_done  = 1'b1;
                n_state = ST_IDLE;
                case (r_func)
                    FUNC_ACT: begin
                        n_last       = act_pick;
                        n_prev_p     = r_p;
                        n_prev_o     = r_o;
                        n_eps        = eps_next;
                        n_res.action = 5'({1'b0, act_pick} - 5'd1);
                    end
                    FUNC_WRITE: begin
                        idx_sel   = r_wact;
                        ram_wdata = r_wval;
                        if ({1'b0, r_wact} < ACT_NUM) begin
                            ram_we        = 1'b1;
                            n_res.q_value = r_wval;
                        end
                    end
                    default: ;
                endcase
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

[hdl/tql_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tql_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/tql_addr.sv]
// Table address unit: (player, opponent) row over two registered steps,
// then row base plus action index. Depends on tql_pkg.
module tql_addr import tql_pkg::*; #(
    parameter int NUM_ACTIONS  = 12,
    parameter int SCORE_LEVELS = 101,
    localparam int AW = $clog2(SCORE_LEVELS * SCORE_LEVELS * NUM_ACTIONS)
) (
    input  logic               i_clk,
    input  t_addr_ctl          i_ctl,
    input  logic [SCORE_W-1:0] i_cur_p,
    input  logic [SCORE_W-1:0] i_cur_o,
    input  logic [SCORE_W-1:0] i_prev_p,
    input  logic [SCORE_W-1:0] i_prev_o,
    input  logic [ACT_W-1:0]   i_idx,
    output logic [AW-1:0]      o_addr
);

    localparam int RW = $clog2(SCORE_LEVELS * SCORE_LEVELS);

    logic [RW-1:0]      r_row;
    logic [AW-1:0]      r_base;
    logic [SCORE_W-1:0] sel_p;
    logic [SCORE_W-1:0] sel_o;

    assign sel_p = i_ctl.sel_prev ? i_prev_p : i_cur_p;
    assign sel_o = i_ctl.sel_prev ? i_prev_o : i_cur_o;

    always_ff @(posedge i_clk) begin
        if (i_ctl.row_en) begin
            r_row <= RW'(RW'(sel_p) * RW'(SCORE_LEVELS)) + RW'(sel_o);
        end
        if (i_ctl.base_en) begin
            r_base <= AW'(AW'(r_row) * AW'(NUM_ACTIONS));
        end
    end

    assign o_addr = r_base + AW'(i_idx);

endmodule

[hdl/tql_mul.sv]
// Shared signed multiplier with a registered product, used for both
// products of the Q update. Depends on tql_pkg.
module tql_mul import tql_pkg::*; (
    input  logic                      i_clk,
    input  logic signed [MUL_A_W-1:0] i_a,
    input  logic signed [MUL_B_W-1:0] i_b,
    output logic signed [PROD_W-1:0]  o_p
);

    logic signed [PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_p = r_p;

endmodule

[hdl/tql_chk.sv]
// Port-level checker for the Q-learning agent, bound to the top level.
// Depends on tql_pkg.
module tql_chk import tql_pkg::*; (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    start,
    input logic    busy,
    input logic    o_done,
    input t_result o_result
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

    a_end_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) && $past(i_rst_n) |-> o_done)
        else $error("busy dropped without a result");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy) && !busy)
        else $error("result strobe outside end of transaction");

    a_act_no_q: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_result.action != 5'sd0) |-> (o_result.q_value == 32'sd0))
        else $error("act result carries a q value");

endmodule

bind tabular_q_learning_agent tql_chk u_tql_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);
